// ===== rtl/rssa_pkg.sv =====
// Shared types and constants for the revolved segment surface area pipeline.
// Used by the top level and by the square root and divider pipelines.
package rssa_pkg;

    localparam int SQRT_BITS = 41;            // slant length bits, 2^-24 units
    localparam int S_W       = 82;            // (dx^2 + dy^2) << 16
    localparam int QUO_BITS  = 78;            // quotient bits kept before saturation
    localparam int N_W       = 105;           // slant * |Q|
    localparam int REM_W     = 32;            // divider remainder, width of |dy|
    localparam int PI_W      = 34;
    localparam int P_W       = QUO_BITS + PI_W;
    localparam logic [PI_W-1:0] PI_Q32 = 34'h3_243F_6A88;
    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic               is_segment;
    } t_in;

    typedef struct packed {
        logic signed [63:0] surface_area;
        logic               unsupported_cell;
    } t_out;

    typedef enum logic [1:0] {
        KIND_ANNULUS,
        KIND_CYLINDER,
        KIND_CONE
    } t_kind;

    // Sideband that rides along the long pipelines.
    typedef struct packed {
        logic        vld;
        logic        unsup;
        t_kind       kind;
        logic        neg;
        logic        sat;
        logic [63:0] x;
        logic [31:0] ady;
    } t_side;

endpackage

// ===== rtl/revolved_segment_surface_area.sv =====
// Revolved segment surface area: one segment in, one signed Q40.24 area out.
// Takes a new beat every cycle while the output side keeps up; every beat
// passes through the 41-stage square root and 78-stage divider pipelines.
// The whole pipeline advances on one enable,
// held whenever the output register is full and stalled.
// Depends on rssa_pkg, rssa_sqrt and rssa_div.
module revolved_segment_surface_area import rssa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    logic r_about_x;
    logic adv;

    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_about_x <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_about_x <= i_cfg_wr_data;
        end
    end

    // Stage 1: pick axial/radial, order by axial coordinate
    logic signed [31:0] ax0, ax1, rd0, rd1;
    logic               swap;
    logic               r_s1_vld, r_s1_unsup;
    logic signed [31:0] r_a0, r_a1, r_r0, r_r1;

    always_comb begin
        ax0  = r_about_x ? i_data.first_x  : i_data.first_y;
        rd0  = r_about_x ? i_data.first_y  : i_data.first_x;
        ax1  = r_about_x ? i_data.second_x : i_data.second_y;
        rd1  = r_about_x ? i_data.second_y : i_data.second_x;
        swap = ax1 < ax0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld   <= i_valid;
            r_s1_unsup <= !i_data.is_segment;
            r_a0       <= swap ? ax1 : ax0;
            r_a1       <= swap ? ax0 : ax1;
            r_r0       <= swap ? rd1 : rd0;
            r_r1       <= swap ? rd0 : rd1;
        end
    end

    // Stage 2: differences, magnitudes, case and multiplier operands
    logic signed [32:0] dx_w, dy_w;
    logic [32:0]        ady_w;
    logic [31:0]        m0, m1, mf, mn;
    logic               sf, sn, far0, hi0;
    t_kind              kind;
    logic               r_s2_vld, r_s2_unsup, r_s2_sf, r_s2_sn, r_s2_rneg;
    t_kind              r_s2_kind;
    logic [31:0]        r_s2_dx, r_s2_mcyl, r_s2_ady, r_s2_mf, r_s2_mn;

    always_comb begin
        dx_w  = {r_a1[31], r_a1} - {r_a0[31], r_a0};
        dy_w  = {r_r1[31], r_r1} - {r_r0[31], r_r0};
        ady_w = dy_w[32] ? 33'd0 - 33'(dy_w) : 33'(dy_w);
        m0    = r_r0[31] ? 32'd0 - 32'(r_r0) : 32'(r_r0);
        m1    = r_r1[31] ? 32'd0 - 32'(r_r1) : 32'(r_r1);
        hi0   = r_r0 > r_r1;
        far0  = !(m0 < m1);
        if (r_a0 == r_a1) begin
            kind = KIND_ANNULUS;
        end else if (r_r0 == r_r1) begin
            kind = KIND_CYLINDER;
        end else begin
            kind = KIND_CONE;
        end
        if (kind == KIND_ANNULUS) begin
            mf = hi0 ? m0 : m1;
            mn = hi0 ? m1 : m0;
            sf = 1'b0;
            sn = 1'b0;
        end else begin
            mf = far0 ? m0 : m1;
            mn = far0 ? m1 : m0;
            sf = far0 ? r_r0[31] : r_r1[31];
            sn = far0 ? r_r1[31] : r_r0[31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s2_vld   <= r_s1_vld;
            r_s2_unsup <= r_s1_unsup;
            r_s2_kind  <= kind;
            r_s2_dx    <= dx_w[31:0];
            r_s2_mcyl  <= (kind == KIND_CYLINDER) ? m0 : dx_w[31:0];
            r_s2_ady   <= ady_w[31:0];
            r_s2_mf    <= mf;
            r_s2_mn    <= mn;
            r_s2_sf    <= sf;
            r_s2_sn    <= sn;
            r_s2_rneg  <= r_r0[31];
        end
    end

    // Stage 3: four independent 32x32 products
    logic        r_s3_vld, r_s3_unsup, r_s3_sf, r_s3_sn, r_s3_rneg;
    t_kind       r_s3_kind;
    logic [31:0] r_s3_ady;
    logic [63:0] r_pa, r_pb, r_pf, r_pn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (adv) begin
            r_s3_vld   <= r_s2_vld;
            r_s3_unsup <= r_s2_unsup;
            r_s3_kind  <= r_s2_kind;
            r_s3_ady   <= r_s2_ady;
            r_s3_sf    <= r_s2_sf;
            r_s3_sn    <= r_s2_sn;
            r_s3_rneg  <= r_s2_rneg;
            r_pa       <= 64'(r_s2_dx) * 64'(r_s2_mcyl);
            r_pb       <= 64'(r_s2_ady) * 64'(r_s2_ady);
            r_pf       <= 64'(r_s2_mf) * 64'(r_s2_mf);
            r_pn       <= 64'(r_s2_mn) * 64'(r_s2_mn);
        end
    end

    // Stage 4: slant radicand and signed square difference
    logic [64:0]        sum_sq;
    logic signed [65:0] tf, tn, diff;
    logic [63:0]        qmag;
    logic [S_W-1:0]     r_s4_s;
    t_side              s4_side, r_s4_side;

    always_comb begin
        sum_sq = 65'(r_pa) + 65'(r_pb);
        tf     = r_s3_sf ? 66'sd0 - $signed({2'b0, r_pf}) : $signed({2'b0, r_pf});
        tn     = r_s3_sn ? 66'sd0 - $signed({2'b0, r_pn}) : $signed({2'b0, r_pn});
        diff   = tf - tn;
        qmag   = diff[65] ? 64'(66'sd0 - diff) : diff[63:0];
        s4_side.vld   = r_s3_vld;
        s4_side.unsup = r_s3_unsup;
        s4_side.kind  = r_s3_kind;
        s4_side.sat   = 1'b0;
        s4_side.ady   = r_s3_ady;
        if (r_s3_kind == KIND_CYLINDER) begin
            s4_side.neg = r_s3_rneg;
            s4_side.x   = r_pa;
        end else begin
            s4_side.neg = diff[65];
            s4_side.x   = qmag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_side.vld <= 1'b0;
        end else if (adv) begin
            r_s4_side <= s4_side;
            r_s4_s    <= S_W'(sum_sq) << 16;
        end
    end

    logic [SQRT_BITS-1:0] root;
    t_side                sq_side;

    rssa_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_val   (r_s4_s),
        .i_side  (r_s4_side),
        .o_root  (root),
        .o_side  (sq_side)
    );

    // Stage 5: slant times |Q| as two partial products
    logic [SQRT_BITS+31:0] r_plo, r_phi;
    t_side                 r_s5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_side.vld <= 1'b0;
        end else if (adv) begin
            r_s5_side <= sq_side;
            r_plo     <= (SQRT_BITS+32)'(root) * (SQRT_BITS+32)'(sq_side.x[31:0]);
            r_phi     <= (SQRT_BITS+32)'(root) * (SQRT_BITS+32)'(sq_side.x[63:32]);
        end
    end

    // Stage 6: sum partials, flag quotients that cannot fit
    logic [N_W-1:0] num;
    logic [N_W-1:0] r_num;
    t_side          s6_side, r_s6_side;

    always_comb begin
        num         = N_W'(r_plo) + (N_W'(r_phi) << 32);
        s6_side     = r_s5_side;
        s6_side.sat = {{(REM_W - N_W + QUO_BITS){1'b0}}, num[N_W-1:QUO_BITS]} >= r_s5_side.ady;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_side.vld <= 1'b0;
        end else if (adv) begin
            r_s6_side <= s6_side;
            r_num     <= num;
        end
    end

    logic [QUO_BITS-1:0] quo;
    t_side               dv_side;

    rssa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_num   (r_num),
        .i_side  (r_s6_side),
        .o_quo   (quo),
        .o_side  (dv_side)
    );

    // Stage 7: times pi, in three 26-bit slices
    logic [QUO_BITS-1:0] y;
    logic [59:0]         r_pp0, r_pp1, r_pp2;
    t_side               r_s7_side;

    assign y = (dv_side.kind == KIND_CONE) ? quo : QUO_BITS'(dv_side.x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_side.vld <= 1'b0;
        end else if (adv) begin
            r_s7_side <= dv_side;
            r_pp0     <= 60'(y[25:0]) * 60'(PI_Q32);
            r_pp1     <= 60'(y[51:26]) * 60'(PI_Q32);
            r_pp2     <= 60'(y[77:52]) * 60'(PI_Q32);
        end
    end

    // Stage 8: combine slices
    logic [P_W-1:0] r_p;
    t_side          r_s8_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_side.vld <= 1'b0;
        end else if (adv) begin
            r_s8_side <= r_s7_side;
            r_p       <= P_W'(r_pp0) + (P_W'(r_pp1) << 26) + (P_W'(r_pp2) << 52);
        end
    end

    // Output: scale per case, saturate cones, apply sign, flag unsupported cells
    logic [63:0] mag;
    t_out        n_out;
    logic        r_ovld;
    t_out        r_out;

    always_comb begin
        case (r_s8_side.kind)
            KIND_ANNULUS:  mag = r_p[103:40];
            KIND_CYLINDER: mag = r_p[102:39];
            KIND_CONE:     mag = (r_s8_side.sat || r_p[P_W-1]) ? MAG_MAX : r_p[P_W-1:48];
            default:       mag = '0;
        endcase
        if (r_s8_side.unsup) begin
            n_out.surface_area     = '0;
            n_out.unsupported_cell = 1'b1;
        end else begin
            n_out.surface_area     = r_s8_side.neg ? $signed(64'd0 - mag) : $signed(mag);
            n_out.unsupported_cell = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (adv) begin
            r_ovld <= r_s8_side.vld;
            r_out  <= n_out;
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_out;

endmodule

// ===== rtl/rssa_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on rssa_pkg for widths and the sideband type.
module rssa_sqrt import rssa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [S_W-1:0]       i_val,
    input  t_side                i_side,
    output logic [SQRT_BITS-1:0] o_root,
    output t_side                o_side
);

    logic [S_W-1:0]       r_e   [1:SQRT_BITS];
    logic [SQRT_BITS-1:0] r_res [1:SQRT_BITS];
    t_side                r_side[1:SQRT_BITS];

    for (genvar j = 0; j < SQRT_BITS; j++) begin : g_stage
        localparam int K = SQRT_BITS - 1 - j;
        logic [S_W-1:0]       e_in;
        logic [S_W-1:0]       trial;
        logic [S_W-1:0]       n_e;
        logic [SQRT_BITS-1:0] res_in;
        logic [SQRT_BITS-1:0] n_res;
        t_side                side_in;
        logic                 ge;

        if (j == 0) begin : g_first
            assign e_in    = i_val;
            assign res_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign e_in    = r_e[j];
            assign res_in  = r_res[j];
            assign side_in = r_side[j];
        end

        // e holds value - res^2; trying bit K adds 2*res*2^K + 2^2K
        always_comb begin
            trial = (S_W'(res_in) << (K + 1)) | (S_W'(1) << (2 * K));
            ge    = e_in >= trial;
            n_e   = ge ? e_in - trial : e_in;
            n_res = res_in | (SQRT_BITS'(ge) << K);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[j+1].vld <= 1'b0;
            end else if (i_en) begin
                r_e[j+1]    <= n_e;
                r_res[j+1]  <= n_res;
                r_side[j+1] <= side_in;
            end
        end
    end

    assign o_root = r_res[SQRT_BITS];
    assign o_side = r_side[SQRT_BITS];

endmodule

// ===== rtl/rssa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage; divisor is side.ady.
// Depends on rssa_pkg for widths and the sideband type.
module rssa_div import rssa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [N_W-1:0]      i_num,
    input  t_side               i_side,
    output logic [QUO_BITS-1:0] o_quo,
    output t_side               o_side
);

    logic [REM_W-1:0]    r_rem [1:QUO_BITS];
    logic [QUO_BITS-1:0] r_nq  [1:QUO_BITS];
    t_side               r_side[1:QUO_BITS];

    for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
        logic [REM_W-1:0]    rem_in;
        logic [REM_W-1:0]    n_rem;
        logic [QUO_BITS-1:0] nq_in;
        logic [REM_W:0]      t;
        logic [REM_W:0]      dv;
        t_side               side_in;
        logic                ge;

        if (j == 0) begin : g_first
            // top bits start as the remainder; saturation covers quotients of 2^78 and above
            assign rem_in  = {{(REM_W - N_W + QUO_BITS){1'b0}}, i_num[N_W-1:QUO_BITS]};
            assign nq_in   = i_num[QUO_BITS-1:0];
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[j];
            assign nq_in   = r_nq[j];
            assign side_in = r_side[j];
        end

        always_comb begin
            t     = {rem_in, nq_in[QUO_BITS-1]};
            dv    = {1'b0, side_in.ady};
            ge    = t >= dv;
            n_rem = ge ? REM_W'(t - dv) : t[REM_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[j+1].vld <= 1'b0;
            end else if (i_en) begin
                r_rem[j+1]  <= n_rem;
                r_nq[j+1]   <= {nq_in[QUO_BITS-2:0], ge};
                r_side[j+1] <= side_in;
            end
        end
    end

    assign o_quo  = r_nq[QUO_BITS];
    assign o_side = r_side[QUO_BITS];

endmodule
